FILE: rtl/uv_sphere_tessellator_top_macros.svh
// Assertion helpers shared by the tessellator RTL.
`ifndef UV_SPHERE_TESSELLATOR_TOP_MACROS_SVH
`define UV_SPHERE_TESSELLATOR_TOP_MACROS_SVH

// same-cycle implication
`define UVST_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("uvst assertion failed");

// next-cycle implication
`define UVST_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("uvst assertion failed");

`endif

FILE: rtl/uvst_pkg.sv
package uvst_pkg;

    localparam int DIVISION_BITS_DEF = 10;
    localparam int CORDIC_STAGES_DEF = 16;

    // every divider runs this many restoring steps (17-bit quotients)
    localparam int DIV_STEPS = 17;

    localparam logic [9:0]  RING_COUNT_RST    = 10'd16;
    localparam logic [9:0]  SEGMENT_COUNT_RST = 10'd32;
    localparam logic [23:0] SPHERE_RADIUS_RST = 24'd65536;

    // 0.6072529350 in Q30
    localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

    typedef enum logic [1:0] {
        CFG_RING_COUNT    = 2'd0,
        CFG_SEGMENT_COUNT = 2'd1,
        CFG_SPHERE_RADIUS = 2'd2
    } cfg_index_t;

    // atan(2^-i) as a phase, 2^32 = full turn
    function automatic logic [29:0] atan_phase(input int unsigned i);
        unique case (i)
            0:  return 30'h20000000;
            1:  return 30'h12E4051E;
            2:  return 30'h09FB385B;
            3:  return 30'h051111D4;
            4:  return 30'h028B0D43;
            5:  return 30'h0145D7E1;
            6:  return 30'h00A2F61E;
            7:  return 30'h00517C55;
            8:  return 30'h0028BE53;
            9:  return 30'h00145F2F;
            10: return 30'h000A2F98;
            11: return 30'h000517CC;
            12: return 30'h00028BE6;
            13: return 30'h000145F3;
            14: return 30'h0000A2FA;
            15: return 30'h0000517D;
            16: return 30'h000028BE;
            17: return 30'h0000145F;
            18: return 30'h00000A30;
            19: return 30'h00000518;
            20: return 30'h0000028C;
            21: return 30'h00000146;
            22: return 30'h000000A3;
            23: return 30'h00000051;
            default: return 30'h0;
        endcase
    endfunction

endpackage

FILE: rtl/uv_sphere_tessellator_top.sv
// UV sphere tessellator.
// Input stream s_*: one word per request. s_tuser selects the operation
// (0 vertex, 1 quad), s_tdata carries ring and segment. A vertex request
// yields one output word with normal, texture coordinates and position; a
// quad request yields two words of triangle corner indices, the second one
// flagged with m_tlast. Vertex words always carry m_tlast high.
// Config port cfg_*: register index and data, always ready; write it only
// while the pipeline is empty.
// Pipeline from input accept to output valid: input register, divider setup,
// 17 restoring divider steps, CORDIC setup, one CORDIC stage per iteration,
// then multiply, round and saturate stages and the output register.
// Throughput: one vertex per cycle while m_tready is high; a quad holds the
// whole pipeline until the first of its two output words is taken.
// Reset clears the configuration to 16 rings, 32 segments, radius 1.0 and
// empties the pipeline. When m_tvalid is high and m_tready is low the whole
// pipeline freezes and s_tready drops; nothing is lost or repeated.
`include "uv_sphere_tessellator_top_macros.svh"

module uv_sphere_tessellator_top #(
    parameter int DIVISION_BITS = uvst_pkg::DIVISION_BITS_DEF,
    parameter int CORDIC_STAGES = uvst_pkg::CORDIC_STAGES_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // ring[9:0], segment[19:10], zero pad
    input  logic         s_tuser,   // func
    output logic         m_tvalid,
    input  logic         m_tready,
    // normal_x, normal_y, normal_z, tex_u, tex_v, pos_x, pos_y, pos_z,
    // corner_a, corner_b, corner_c, zero pad
    output logic [223:0] m_tdata,
    output logic         m_tlast,   // last
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [23:0]  cfg_data
);

    localparam int DB = DIVISION_BITS;
    localparam int CS = CORDIC_STAGES;
    localparam int NS = uvst_pkg::DIV_STEPS;

    // ---------------- configuration ----------------
    logic [9:0]  ring_count_reg;
    logic [9:0]  segment_count_reg;
    logic [23:0] sphere_radius_reg;
    logic [9:0]  rce;
    logic [9:0]  sce;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ring_count_reg    <= uvst_pkg::RING_COUNT_RST;
            segment_count_reg <= uvst_pkg::SEGMENT_COUNT_RST;
            sphere_radius_reg <= uvst_pkg::SPHERE_RADIUS_RST;
        end else if (cfg_valid && cfg_ready) begin
            unique case (uvst_pkg::cfg_index_t'(cfg_index))
                uvst_pkg::CFG_RING_COUNT:    ring_count_reg    <= cfg_data[9:0];
                uvst_pkg::CFG_SEGMENT_COUNT: segment_count_reg <= cfg_data[9:0];
                uvst_pkg::CFG_SPHERE_RADIUS: sphere_radius_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // zero count acts as one
    assign rce = (ring_count_reg == 10'd0) ? 10'd1 : ring_count_reg;
    assign sce = (segment_count_reg == 10'd0) ? 10'd1 : segment_count_reg;

    // ---------------- flow control ----------------
    logic adv;
    logic ov_reg, ohalf_reg, ofunc_reg;

    assign adv      = !ov_reg || (m_tready && (!ofunc_reg || ohalf_reg));
    assign s_tready = adv;

    // ---------------- input stage ----------------
    logic       in_v_reg, in_func_reg;
    logic [9:0] in_ring_reg, in_seg_reg;
    logic [9:0] ring_next, seg_next;

    always_comb begin
        if (s_tuser) begin
            ring_next = (s_tdata[9:0] > rce - 10'd1) ? rce - 10'd1 : s_tdata[9:0];
            seg_next  = (s_tdata[19:10] > sce - 10'd1) ? sce - 10'd1 : s_tdata[19:10];
        end else begin
            ring_next = (s_tdata[9:0] > rce) ? rce : s_tdata[9:0];
            seg_next  = (s_tdata[19:10] > sce) ? sce : s_tdata[19:10];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (adv) begin
            in_v_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            in_func_reg <= s_tuser;
            in_ring_reg <= ring_next;
            in_seg_reg  <= seg_next;
        end
    end

    // ---------------- divider setup ----------------
    // dividers: 0 theta (ring/rc), 1 phi (seg/sc), 2 tex_u, 3 tex_v
    logic [9:0]  den [0:3];
    logic [26:0] dvd_init [0:3];
    logic [20:0] a_full;
    logic [19:0] a_next, b_next;

    always_comb begin
        den[0] = rce;
        den[1] = sce;
        den[2] = sce;
        den[3] = rce;
        dvd_init[0] = 27'(in_ring_reg) << DB;
        dvd_init[1] = 27'(in_seg_reg) << DB;
        dvd_init[2] = {1'b0, sce - in_seg_reg, 16'h0} + 27'(sce[9:1]);
        dvd_init[3] = {1'b0, rce - in_ring_reg, 16'h0} + 27'(rce[9:1]);
        a_full = 21'(in_ring_reg) * (21'(sce) + 21'd1) + 21'(in_seg_reg);
        a_next = a_full[19:0];
        b_next = a_next + 20'(sce) + 20'd1;
    end

    logic        dv_v_reg    [0:NS];
    logic        dv_func_reg [0:NS];
    logic [19:0] dv_a_reg    [0:NS];
    logic [19:0] dv_b_reg    [0:NS];
    logic [9:0]  dv_rem_reg  [0:NS][0:3];
    logic [16:0] dv_dvd_reg  [0:NS][0:3];
    logic [16:0] dv_quo_reg  [0:NS][0:3];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_v_reg[0] <= 1'b0;
        end else if (adv) begin
            dv_v_reg[0] <= in_v_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dv_func_reg[0] <= in_func_reg;
            dv_a_reg[0]    <= a_next;
            dv_b_reg[0]    <= b_next;
            for (int j = 0; j < 4; j++) begin
                dv_rem_reg[0][j] <= dvd_init[j][26:17];
                dv_dvd_reg[0][j] <= dvd_init[j][16:0];
                dv_quo_reg[0][j] <= 17'd0;
            end
        end
    end

    // one restoring quotient bit per stage
    for (genvar k = 0; k < NS; k++) begin : g_div
        logic [10:0] trial [0:3];
        logic [3:0]  ge;
        logic [9:0]  rem_next [0:3];

        always_comb begin
            for (int j = 0; j < 4; j++) begin
                trial[j]    = {dv_rem_reg[k][j], dv_dvd_reg[k][j][16]};
                ge[j]       = trial[j] >= {1'b0, den[j]};
                rem_next[j] = ge[j] ? 10'(trial[j] - {1'b0, den[j]}) : trial[j][9:0];
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                dv_v_reg[k+1] <= 1'b0;
            end else if (adv) begin
                dv_v_reg[k+1] <= dv_v_reg[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dv_func_reg[k+1] <= dv_func_reg[k];
                dv_a_reg[k+1]    <= dv_a_reg[k];
                dv_b_reg[k+1]    <= dv_b_reg[k];
                for (int j = 0; j < 4; j++) begin
                    dv_rem_reg[k+1][j] <= rem_next[j];
                    dv_dvd_reg[k+1][j] <= {dv_dvd_reg[k][j][15:0], 1'b0};
                    dv_quo_reg[k+1][j] <= {dv_quo_reg[k][j][15:0], ge[j]};
                end
            end
        end
    end

    // ---------------- CORDIC ----------------
    logic [31:0] phase_next [0:1];

    always_comb begin
        phase_next[0] = 32'(dv_quo_reg[NS][0][DB:0]) << (31 - DB);
        phase_next[1] = 32'(dv_quo_reg[NS][1][DB:0]) << (32 - DB);
    end

    logic               cr_v_reg    [0:CS];
    logic               cr_func_reg [0:CS];
    logic [19:0]        cr_a_reg    [0:CS];
    logic [19:0]        cr_b_reg    [0:CS];
    logic [16:0]        cr_tu_reg   [0:CS];
    logic [16:0]        cr_tv_reg   [0:CS];
    logic signed [32:0] cr_x_reg    [0:CS][0:1];
    logic signed [32:0] cr_y_reg    [0:CS][0:1];
    logic signed [32:0] cr_z_reg    [0:CS][0:1];
    logic [1:0]         cr_quad_reg [0:CS][0:1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cr_v_reg[0] <= 1'b0;
        end else if (adv) begin
            cr_v_reg[0] <= dv_v_reg[NS];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cr_func_reg[0] <= dv_func_reg[NS];
            cr_a_reg[0]    <= dv_a_reg[NS];
            cr_b_reg[0]    <= dv_b_reg[NS];
            cr_tu_reg[0]   <= dv_quo_reg[NS][2];
            cr_tv_reg[0]   <= dv_quo_reg[NS][3];
            for (int j = 0; j < 2; j++) begin
                cr_x_reg[0][j]    <= uvst_pkg::CORDIC_GAIN_Q30;
                cr_y_reg[0][j]    <= 33'sd0;
                cr_z_reg[0][j]    <= $signed({3'b000, phase_next[j][29:0]});
                cr_quad_reg[0][j] <= phase_next[j][31:30];
            end
        end
    end

    for (genvar i = 0; i < CS; i++) begin : g_cordic
        logic signed [32:0] dx [0:1];
        logic signed [32:0] dy [0:1];
        logic signed [32:0] x_next [0:1];
        logic signed [32:0] y_next [0:1];
        logic signed [32:0] z_next [0:1];
        logic signed [32:0] at;

        always_comb begin
            at = $signed({3'b000, uvst_pkg::atan_phase(i)});
            for (int j = 0; j < 2; j++) begin
                dx[j] = cr_y_reg[i][j] >>> i;
                dy[j] = cr_x_reg[i][j] >>> i;
                if (!cr_z_reg[i][j][32]) begin
                    x_next[j] = cr_x_reg[i][j] - dx[j];
                    y_next[j] = cr_y_reg[i][j] + dy[j];
                    z_next[j] = cr_z_reg[i][j] - at;
                end else begin
                    x_next[j] = cr_x_reg[i][j] + dx[j];
                    y_next[j] = cr_y_reg[i][j] - dy[j];
                    z_next[j] = cr_z_reg[i][j] + at;
                end
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cr_v_reg[i+1] <= 1'b0;
            end else if (adv) begin
                cr_v_reg[i+1] <= cr_v_reg[i];
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                cr_func_reg[i+1] <= cr_func_reg[i];
                cr_a_reg[i+1]    <= cr_a_reg[i];
                cr_b_reg[i+1]    <= cr_b_reg[i];
                cr_tu_reg[i+1]   <= cr_tu_reg[i];
                cr_tv_reg[i+1]   <= cr_tv_reg[i];
                for (int j = 0; j < 2; j++) begin
                    cr_x_reg[i+1][j]    <= x_next[j];
                    cr_y_reg[i+1][j]    <= y_next[j];
                    cr_z_reg[i+1][j]    <= z_next[j];
                    cr_quad_reg[i+1][j] <= cr_quad_reg[i][j];
                end
            end
        end
    end

    // quadrant fold-back: index 0 theta, 1 phi
    logic signed [32:0] cos_v [0:1];
    logic signed [32:0] sin_v [0:1];

    always_comb begin
        for (int j = 0; j < 2; j++) begin
            unique case (cr_quad_reg[CS][j])
                2'd0: begin
                    cos_v[j] = cr_x_reg[CS][j];
                    sin_v[j] = cr_y_reg[CS][j];
                end
                2'd1: begin
                    cos_v[j] = -cr_y_reg[CS][j];
                    sin_v[j] = cr_x_reg[CS][j];
                end
                2'd2: begin
                    cos_v[j] = -cr_x_reg[CS][j];
                    sin_v[j] = -cr_y_reg[CS][j];
                end
                default: begin
                    cos_v[j] = cr_y_reg[CS][j];
                    sin_v[j] = -cr_x_reg[CS][j];
                end
            endcase
        end
    end

    // ---------------- normal products ----------------
    logic               m1_v_reg, m2_v_reg, m3_v_reg;
    logic               m1_func_reg, m2_func_reg, m3_func_reg;
    logic [19:0]        m1_a_reg, m2_a_reg, m3_a_reg;
    logic [19:0]        m1_b_reg, m2_b_reg, m3_b_reg;
    logic [16:0]        m1_tu_reg, m2_tu_reg, m3_tu_reg;
    logic [16:0]        m1_tv_reg, m2_tv_reg, m3_tv_reg;
    logic signed [65:0] m1_px_reg, m1_pz_reg;
    logic signed [32:0] m1_ny_reg;
    logic signed [32:0] m2_nx_reg, m2_ny_reg, m2_nz_reg;
    logic signed [57:0] m3_ppx_reg, m3_ppy_reg, m3_ppz_reg;
    logic signed [15:0] m3_qx_reg, m3_qy_reg, m3_qz_reg;

    logic signed [65:0] rnd_x, rnd_z;
    logic signed [32:0] n30 [0:2];
    logic signed [32:0] q_sum [0:2];
    logic signed [17:0] q_sh [0:2];
    logic signed [15:0] q_sat [0:2];
    logic signed [24:0] rad_s;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m1_v_reg <= 1'b0;
            m2_v_reg <= 1'b0;
            m3_v_reg <= 1'b0;
        end else if (adv) begin
            m1_v_reg <= cr_v_reg[CS];
            m2_v_reg <= m1_v_reg;
            m3_v_reg <= m2_v_reg;
        end
    end

    always_comb begin
        rnd_x  = m1_px_reg + (66'sd1 <<< 29);
        rnd_z  = m1_pz_reg + (66'sd1 <<< 29);
        n30[0] = m2_nx_reg;
        n30[1] = m2_ny_reg;
        n30[2] = m2_nz_reg;
        for (int j = 0; j < 3; j++) begin
            q_sum[j] = n30[j] + 33'sd16384;
            q_sh[j]  = q_sum[j][32:15];
            if (q_sh[j] > 18'sd32767) begin
                q_sat[j] = 16'sh7FFF;
            end else if (q_sh[j] < -18'sd32768) begin
                q_sat[j] = 16'sh8000;
            end else begin
                q_sat[j] = q_sh[j][15:0];
            end
        end
        rad_s = $signed({1'b0, sphere_radius_reg});
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m1_func_reg <= cr_func_reg[CS];
            m1_a_reg    <= cr_a_reg[CS];
            m1_b_reg    <= cr_b_reg[CS];
            m1_tu_reg   <= cr_tu_reg[CS];
            m1_tv_reg   <= cr_tv_reg[CS];
            m1_px_reg   <= cos_v[1] * sin_v[0];
            m1_pz_reg   <= sin_v[1] * sin_v[0];
            m1_ny_reg   <= cos_v[0];

            m2_func_reg <= m1_func_reg;
            m2_a_reg    <= m1_a_reg;
            m2_b_reg    <= m1_b_reg;
            m2_tu_reg   <= m1_tu_reg;
            m2_tv_reg   <= m1_tv_reg;
            m2_nx_reg   <= rnd_x[62:30];
            m2_ny_reg   <= m1_ny_reg;
            m2_nz_reg   <= rnd_z[62:30];

            m3_func_reg <= m2_func_reg;
            m3_a_reg    <= m2_a_reg;
            m3_b_reg    <= m2_b_reg;
            m3_tu_reg   <= m2_tu_reg;
            m3_tv_reg   <= m2_tv_reg;
            m3_qx_reg   <= q_sat[0];
            m3_qy_reg   <= q_sat[1];
            m3_qz_reg   <= q_sat[2];
            m3_ppx_reg  <= rad_s * m2_nx_reg;
            m3_ppy_reg  <= rad_s * m2_ny_reg;
            m3_ppz_reg  <= rad_s * m2_nz_reg;
        end
    end

    // ---------------- position round/saturate, output register ----------------
    logic signed [57:0] pp [0:2];
    logic signed [57:0] p_sum [0:2];
    logic signed [27:0] p_sh [0:2];
    logic signed [24:0] p_sat [0:2];

    always_comb begin
        pp[0] = m3_ppx_reg;
        pp[1] = m3_ppy_reg;
        pp[2] = m3_ppz_reg;
        for (int j = 0; j < 3; j++) begin
            p_sum[j] = pp[j] + (58'sd1 <<< 29);
            p_sh[j]  = p_sum[j][57:30];
            if (p_sh[j] > 28'sd16777215) begin
                p_sat[j] = 25'sh0FFFFFF;
            end else if (p_sh[j] < -28'sd16777216) begin
                p_sat[j] = 25'sh1000000;
            end else begin
                p_sat[j] = p_sh[j][24:0];
            end
        end
    end

    logic signed [15:0] onx_reg, ony_reg, onz_reg;
    logic [16:0]        otu_reg, otv_reg;
    logic signed [24:0] opx_reg, opy_reg, opz_reg;
    logic [19:0]        oa_reg, ob_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ov_reg    <= 1'b0;
            ohalf_reg <= 1'b0;
        end else if (adv) begin
            ov_reg    <= m3_v_reg;
            ohalf_reg <= 1'b0;
        end else if (m_tready) begin
            // first triangle of a quad taken
            ohalf_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ofunc_reg <= m3_func_reg;
            onx_reg   <= m3_qx_reg;
            ony_reg   <= m3_qy_reg;
            onz_reg   <= m3_qz_reg;
            otu_reg   <= m3_tu_reg;
            otv_reg   <= m3_tv_reg;
            opx_reg   <= p_sat[0];
            opy_reg   <= p_sat[1];
            opz_reg   <= p_sat[2];
            oa_reg    <= m3_a_reg;
            ob_reg    <= m3_b_reg;
        end
    end

    logic [19:0]  ca, cb, cc;
    logic [156:0] vtx_bits;

    always_comb begin
        if (!ofunc_reg) begin
            ca = 20'd0;
            cb = 20'd0;
            cc = 20'd0;
            vtx_bits = {opz_reg, opy_reg, opx_reg, otv_reg, otu_reg,
                        onz_reg, ony_reg, onx_reg};
        end else begin
            vtx_bits = '0;
            if (ohalf_reg) begin
                ca = ob_reg;
                cb = ob_reg + 20'd1;
                cc = oa_reg + 20'd1;
            end else begin
                ca = oa_reg;
                cb = ob_reg;
                cc = oa_reg + 20'd1;
            end
        end
    end

    assign m_tvalid = ov_reg;
    assign m_tlast  = !ofunc_reg || ohalf_reg;
    assign m_tdata  = {7'd0, cc, cb, ca, vtx_bits};

    // ---------------- checks ----------------
    `UVST_ASSERT_IMP(a_quad_blocks_input, aclk, aresetn, ov_reg && ofunc_reg && !ohalf_reg, !s_tready)
    `UVST_ASSERT_NXT(a_quad_second_word, aclk, aresetn, m_tvalid && m_tready && ofunc_reg && !ohalf_reg, m_tvalid && ohalf_reg && m_tlast)
    `UVST_ASSERT_NXT(a_stall_freezes_pipe, aclk, aresetn, !s_tready, $stable(dv_v_reg[NS]) && $stable(m3_v_reg))

endmodule
